[sv/rcm_pkg.sv]
package rcm_pkg;

  localparam int MAX_STEPS    = 1000;
  localparam int SINE_ENTRIES = 1024;
  localparam int MAX_VIEW     = 4096;

  localparam int K_W   = $clog2(MAX_STEPS + 1);
  localparam int IDX_W = $clog2(SINE_ENTRIES + 1);
  localparam int DIM_W = $clog2(MAX_VIEW + 1);
  localparam int P_W   = K_W + 15;
  localparam int N_W   = K_W + 18;
  localparam int NUM_W = 19 + DIM_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam int              TILE_Q       = 163840;
  localparam int              DIST_MIN     = 164;
  localparam int              HEIGHT_SCALE = 327680;

  localparam logic [2:0] REG_CAMERA_X       = 3'd0;
  localparam logic [2:0] REG_CAMERA_Y       = 3'd1;
  localparam logic [2:0] REG_CAMERA_HEADING = 3'd2;
  localparam logic [2:0] REG_VIEW_WIDTH     = 3'd3;
  localparam logic [2:0] REG_VIEW_HEIGHT    = 3'd4;
  localparam logic [2:0] REG_ANGLE_STEP     = 3'd5;

  typedef logic [14:0] sine_tab_t [SINE_ENTRIES + 1];
  typedef logic [1:0]  tile_map_t [64];
  typedef logic [31:0] colour_t [4];

  localparam tile_map_t TILE_MAP = '{
    2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2,
    2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd1, 2'd3, 2'd3, 2'd0, 2'd2,
    2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd0, 2'd3,
    2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2,
    2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
    2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3
  };

  localparam colour_t CODE_COLOUR = '{
    32'h6666_6666, 32'hFFFF_0000, 32'hFF00_FF00, 32'hFF00_00FF
  };

  // Quarter-wave sine in Q2.14, evaluated at elaboration by a Taylor series.
  // The six series terms divide by 2k(2k+1) for k = 1..6, with signs alternating.
  function automatic sine_tab_t build_sine();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      x    = longint'(i) * HALF_PI_Q30 / SINE_ENTRIES;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      if (sum < 0) sum = 0;
      r = (longint'(sum) + 32768) >> 16;
      if (r > 16384) r = 16384;
      tab[i] = 15'(r);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  function automatic logic signed [15:0] sin_q14(input logic [15:0] a);
    logic [14:0]             w;
    logic [14 + IDX_W:0]     scaled;
    logic [IDX_W-1:0]        idx;
    logic signed [15:0]      mag;
    w = {1'b0, a[13:0]};
    if (a[14]) w = 15'd16384 - w;
    scaled = (IDX_W + 15)'(w) * (IDX_W + 15)'(SINE_ENTRIES);
    idx = scaled[14 +: IDX_W];
    mag = $signed({1'b0, SINE_TAB[idx]});
    return a[15] ? -mag : mag;
  endfunction

endpackage

[sv/raycast_column_march.sv]
// Column ray marcher over a fixed 8x8 tile map.
// Input channel: in_valid/in_stall carry a screen column. A transaction is
// taken only while the sequencer is idle; in_stall is high for the rest.
// Output channel: out_valid/out_stall carry the wall span, wall code,
// colour and step count of the ray, one result per column.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// (camera x, camera y, heading, width, height, angle step); write only
// while no column is in flight. Unknown indexes are ignored.
// Sequence: setup and table lookups (S_OFF, S_ANG, S_LK1 to S_LK3), one
// march step per cycle (at most MAX_STEPS), the distance multiply in
// S_DIST, the divider in S_DIV for the wall height and the output load in
// S_FIN. A new column is taken only after the previous one leaves S_FIN.
// The march loop steps through one adder per axis.
// A result waits in the output register while out_stall is high; the
// next column can be accepted meanwhile and its result holds in the
// final state until the output register frees up.
// Reset restores the default camera and view and empties the pipeline.
module raycast_column_march (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] y_start,
  output logic [12:0] y_end,
  output logic [1:0]  wall_code,
  output logic [31:0] rgba,
  output logic [9:0]  march_steps,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data
);
  import rcm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_OFF   = 10'b0000000010,
    S_ANG   = 10'b0000000100,
    S_LK1   = 10'b0000001000,
    S_LK2   = 10'b0000010000,
    S_LK3   = 10'b0000100000,
    S_MARCH = 10'b0001000000,
    S_DIST  = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state;

  logic [14:0] camera_x, camera_y;
  logic [15:0] camera_heading;
  logic [12:0] view_width, view_height;
  logic [21:0] angle_step;

  logic [11:0]             col;
  logic signed [36:0]      off_prod;
  logic [15:0]             off, angle;
  logic signed [15:0]      rom_q, dx, dy;
  logic signed [N_W-1:0]   nx, ny;
  logic [K_W-1:0]          k;
  logic [1:0]              code;
  logic signed [P_W:0]     p;
  logic [NUM_W-1:0]        num;
  logic [P_W-1:0]          den;
  logic [P_W:0]            rem;
  logic [CNT_W-1:0]        cnt;

  logic [DIM_W-1:0] wv, hv;
  logic [13:0]      col2;
  logic signed [37:0] off_rnd;
  logic [15:0]      lut_angle;
  logic [2:0]       tx, ty;
  logic             x_out, y_out;
  logic [1:0]       map_code;
  logic [P_W:0]     shifted;
  logic             fits;
  logic [DIM_W:0]   span_lo, span_hi;
  logic             tall;

  assign wv = (DIM_W'(view_width) > DIM_W'(MAX_VIEW)) ? DIM_W'(MAX_VIEW)
                                                     : DIM_W'(view_width);
  assign hv = (DIM_W'(view_height) > DIM_W'(MAX_VIEW)) ? DIM_W'(MAX_VIEW)
                                                      : DIM_W'(view_height);
  assign col2    = {1'b0, col, 1'b0};
  assign off_rnd = 38'(off_prod) + 38'sd256;

  always_comb begin
    case (state)
      S_LK1:   lut_angle = angle + 16'd16384;
      S_LK2:   lut_angle = angle;
      default: lut_angle = off + 16'd16384;
    endcase
  end

  // Tile coordinates by comparing against the tile boundaries.
  always_comb begin
    tx = '0;
    ty = '0;
    for (int j = 1; j < 8; j++) begin
      if (nx >= N_W'(j * TILE_Q)) tx = 3'(j);
      if (ny >= N_W'(j * TILE_Q)) ty = 3'(j);
    end
    x_out = nx[N_W-1] || (nx >= N_W'(8 * TILE_Q));
    y_out = ny[N_W-1] || (ny >= N_W'(8 * TILE_Q));
    map_code = TILE_MAP[{ty, tx}];
  end

  assign shifted = {rem[P_W-1:0], num[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den};
  assign tall    = num >= NUM_W'(hv);
  assign span_lo = (DIM_W + 1)'(hv) - (DIM_W + 1)'(num);
  assign span_hi = (DIM_W + 1)'(hv) + (DIM_W + 1)'(num);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x       <= 15'd6144;
      camera_y       <= 15'd6144;
      camera_heading <= 16'd0;
      view_width     <= 13'd640;
      view_height    <= 13'd480;
      angle_step     <= 22'd6554;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CAMERA_X:       camera_x       <= cfg_data[14:0];
        REG_CAMERA_Y:       camera_y       <= cfg_data[14:0];
        REG_CAMERA_HEADING: camera_heading <= cfg_data[15:0];
        REG_VIEW_WIDTH:     view_width     <= cfg_data[12:0];
        REG_VIEW_HEIGHT:    view_height    <= cfg_data[12:0];
        REG_ANGLE_STEP:     angle_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The final state reloads the output register itself.
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            col   <= column;
            state <= S_OFF;
          end
        end
        S_OFF: begin
          off_prod <= (37'(signed'({1'b0, col2})) - 37'(signed'({1'b0, wv})))
                      * 37'(signed'({1'b0, angle_step}));
          state <= S_ANG;
        end
        S_ANG: begin
          off   <= off_rnd[24:9];
          angle <= camera_heading + off_rnd[24:9];
          state <= S_LK1;
        end
        S_LK1: begin
          rom_q <= sin_q14(lut_angle);
          state <= S_LK2;
        end
        S_LK2: begin
          dx    <= rom_q;
          rom_q <= sin_q14(lut_angle);
          state <= S_LK3;
        end
        S_LK3: begin
          dy    <= rom_q;
          rom_q <= sin_q14(lut_angle);
          nx    <= N_W'(camera_x) * N_W'(40);
          ny    <= N_W'(camera_y) * N_W'(40);
          k     <= '0;
          code  <= '0;
          state <= S_MARCH;
        end
        S_MARCH: begin
          if (x_out || y_out) begin
            state <= S_DIST;
          end else if (map_code != 2'd0) begin
            code  <= map_code;
            state <= S_DIST;
          end else begin
            k  <= k + 1'b1;
            nx <= nx + N_W'(dx);
            ny <= ny + N_W'(dy);
            if (k == K_W'(MAX_STEPS - 1)) state <= S_DIST;
          end
        end
        S_DIST: begin
          // rom_q still holds the cosine of the column offset.
          p     <= (P_W + 1)'(signed'({1'b0, k})) * (P_W + 1)'(rom_q);
          num   <= NUM_W'(HEIGHT_SCALE) * NUM_W'(hv);
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0 && p < (P_W + 1)'(DIST_MIN)) begin
            num   <= NUM_W'(hv);
            state <= S_FIN;
          end else begin
            if (cnt == '0) den <= p[P_W-1:0];
            if (cnt != '0) begin
              rem <= fits ? shifted - {1'b0, den} : shifted;
              num <= {num[NUM_W-2:0], fits};
            end
            cnt <= cnt + 1'b1;
            if (cnt == CNT_W'(NUM_W)) state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            y_start     <= tall ? 13'd0 : 13'(span_lo >> 1);
            y_end       <= tall ? 13'(hv) : 13'(span_hi >> 1);
            wall_code   <= code;
            rgba        <= CODE_COLOUR[code];
            march_steps <= (k > K_W'(1023)) ? 10'd1023 : 10'(k);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MARCH |-> k < K_W'(MAX_STEPS))
    else $error("march step count out of range");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt <= CNT_W'(NUM_W))
    else $error("divider count out of range");
  a_take: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && in_valid |=> state == S_OFF)
    else $error("accepted column not started");
`endif

endmodule
